// ----- src/shelf_atlas_packer_macros.svh -----
// ----------------------------------------------------------------------------
// shelf atlas packer assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef SHELF_ATLAS_PACKER_MACROS_SVH
`define SHELF_ATLAS_PACKER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SAP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sap check failed");

// next-cycle implication, disabled in reset
`define SAP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sap check failed");

`endif

// ----- src/sap_pkg.sv -----
// ----------------------------------------------------------------------------
// sap_pkg
// shared types and constants of the shelf atlas packer
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int DEF_MAX_SHELVES = 64;
    localparam int DEF_MAX_SIDE    = 8192;

    localparam int CFG_W     = 14;
    localparam int GLYPH_W   = 13;
    localparam int AIDX_W    = 16;
    localparam int ACOUNT_W  = 17;

    localparam logic [CFG_W-1:0]    INIT_SIZE_RESET = 14'd512;
    localparam logic [CFG_W-1:0]    MAX_SIZE_RESET  = 14'd4096;
    localparam int                  MIN_SIDE        = 16;
    localparam logic [ACOUNT_W-1:0] COUNT_CAP       = 17'd65536;

    // configuration register indexes
    localparam logic CFG_INIT_SIZE = 1'b0;
    localparam logic CFG_MAX_SIZE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REACH,
        ST_LAUNCH,
        ST_SCAN,
        ST_FINISH
    } sap_state_t;

    // per-cell control
    typedef struct packed {
        logic kill;
        logic wr;
    } sap_ctl_t;

endpackage

// ----- src/sap_cell.sv -----
// ----------------------------------------------------------------------------
// sap_cell
// one shelf: next free x, top row, bottom extent, and the scan token
// ----------------------------------------------------------------------------
module sap_cell
    import sap_pkg::*;
#(
    parameter int DW = 14
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tok_in,
    output logic          tok_out,
    input  sap_ctl_t      ctl,
    input  logic [DW-1:0] wr_x,
    input  logic [DW-1:0] wr_y,
    input  logic [DW-1:0] wr_ext,
    output logic [DW-1:0] rd_x,
    output logic [DW-1:0] rd_y,
    output logic [DW-1:0] rd_ext
);

    logic          tok_reg;
    logic [DW-1:0] x_reg;
    logic [DW-1:0] y_reg;
    logic [DW-1:0] ext_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in & ~ctl.kill;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            x_reg   <= wr_x;
            y_reg   <= wr_y;
            ext_reg <= wr_ext;
        end
    end

    assign tok_out = tok_reg;
    // only the token holder drives the shared read bus
    assign rd_x    = tok_reg ? x_reg   : '0;
    assign rd_y    = tok_reg ? y_reg   : '0;
    assign rd_ext  = tok_reg ? ext_reg : '0;

endmodule

// ----- src/shelf_atlas_packer.sv -----
// ----------------------------------------------------------------------------
// shelf_atlas_packer
// shelf packing of glyph rectangles into square atlases, one shelf per cell
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | in_valid/in_stall  | glyph_width, glyph_height
//  output   | out       | out_valid/out_stall| place_x/y, atlas_index/side, flags
//  config   | in        | cfg_we             | cfg_index, cfg_data
//
//  one glyph at a time: reach doublings, then a launch and a shelf scan per
//  pass, one more pass after every atlas doubling or fresh atlas
//  the scan token walks the cell row one shelf per cycle, which sets the rate
//  reset leaves no atlas; the first glyph starts one, no clearing pass
//  a waiting result in the output register does not block the next transfer
//  on the input side; only the finish step waits on out_stall
module shelf_atlas_packer
    import sap_pkg::*;
#(
    parameter int MAX_SHELVES = DEF_MAX_SHELVES,
    parameter int MAX_SIDE    = DEF_MAX_SIDE
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [GLYPH_W-1:0] glyph_width,
    input  logic [GLYPH_W-1:0] glyph_height,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [GLYPH_W-1:0] place_x,
    output logic [GLYPH_W-1:0] place_y,
    output logic [AIDX_W-1:0]  atlas_index,
    output logic [CFG_W-1:0]   atlas_side,
    output logic               was_resized,
    output logic               was_new_atlas,
    output logic               too_large
);

    localparam int IW     = $clog2(MAX_SHELVES);
    localparam int CNTW   = $clog2(MAX_SHELVES + 1);
    localparam int SIDE_W = $clog2(MAX_SIDE) + 1;
    // working width for sides, coordinates and glyph sums
    localparam int SW     = ((SIDE_W > GLYPH_W) ? SIDE_W : GLYPH_W) + 1;

    // configuration registers
    logic [CFG_W-1:0] cfg_init_reg;
    logic [CFG_W-1:0] cfg_max_reg;

    // control state
    sap_state_t          state_reg, state_next;
    logic [SW-1:0]       side_reg, side_next;
    logic [CNTW-1:0]     count_reg, count_next;
    logic [ACOUNT_W-1:0] acount_reg, acount_next;
    logic [IW-1:0]       scan_reg, scan_next;
    logic                out_valid_reg, out_valid_next;

    // per-glyph working registers
    logic [GLYPH_W-1:0] w_reg, w_next;
    logic [GLYPH_W-1:0] h_reg, h_next;
    logic [SW-1:0]      init_reg, init_next;
    logic [SW-1:0]      maxs_reg, maxs_next;
    logic [SW-1:0]      reach_reg, reach_next;
    logic [SW-1:0]      px_reg, px_next;
    logic [SW-1:0]      py_reg, py_next;
    logic               fresh_reg, fresh_next;
    logic               resized_reg, resized_next;
    logic               big_reg, big_next;

    // output register
    logic [GLYPH_W-1:0] ox_reg, oy_reg;
    logic [AIDX_W-1:0]  oidx_reg;
    logic [CFG_W-1:0]   oside_reg;
    logic               ores_reg, onew_reg, obig_reg;
    logic               out_load;

    // cell row interface
    logic              launch;
    logic              kill;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    logic [SW-1:0]     wr_x, wr_y, wr_ext;
    logic [MAX_SHELVES:0] tok;
    logic [SW-1:0]     cell_x   [MAX_SHELVES];
    logic [SW-1:0]     cell_y   [MAX_SHELVES];
    logic [SW-1:0]     cell_ext [MAX_SHELVES];
    logic [SW-1:0]     rd_x, rd_y, rd_ext;

    // clamped register values and shelf arithmetic
    logic [SW-1:0]     init_clamp, max_clamp;
    logic [SW:0]       xe, ye, reach2, side2, ny, ne, nx;
    logic              fits, is_last, room;

    function automatic logic [SW-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [SW-1:0] e;
        e = SW'(v);
        if (e < SW'(MIN_SIDE))
        begin
            return SW'(MIN_SIDE);
        end
        else if (e > SW'(MAX_SIDE))
        begin
            return SW'(MAX_SIDE);
        end
        return e;
    endfunction

    assign init_clamp = clamp_side(cfg_init_reg);
    assign max_clamp  = clamp_side(cfg_max_reg);

    // ------------------------------------------------------------------ cells
    assign tok[0] = launch;

    for (genvar i = 0; i < MAX_SHELVES; i++)
    begin : g_cell
        sap_ctl_t ctl;
        assign ctl.kill = kill;
        assign ctl.wr   = wr_en && (wr_idx == IW'(i));

        sap_cell #(.DW(SW)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .ctl     (ctl),
            .wr_x    (wr_x),
            .wr_y    (wr_y),
            .wr_ext  (wr_ext),
            .rd_x    (cell_x[i]),
            .rd_y    (cell_y[i]),
            .rd_ext  (cell_ext[i])
        );
    end

    // token holder's shelf on the shared bus
    always_comb
    begin
        rd_x   = '0;
        rd_y   = '0;
        rd_ext = '0;
        for (int i = 0; i < MAX_SHELVES; i++)
        begin
            rd_x   = rd_x   | cell_x[i];
            rd_y   = rd_y   | cell_y[i];
            rd_ext = rd_ext | cell_ext[i];
        end
    end

    // --------------------------------------------------------- shelf checks
    assign xe      = {1'b0, rd_x} + (SW+1)'(w_reg);
    assign ye      = {1'b0, rd_y} + (SW+1)'(h_reg);
    assign nx      = xe + (SW+1)'(1);
    assign fits    = (xe < {1'b0, side_reg}) && (ye < {1'b0, side_reg});
    assign is_last = (CNTW'(scan_reg) == (count_reg - CNTW'(1)));
    assign ny      = {1'b0, rd_ext} + (SW+1)'(1);
    assign ne      = ny + (SW+1)'(h_reg);
    assign room    = (ne <= {1'b0, side_reg}) && ((SW'(w_reg)) < side_reg)
                     && (count_reg < CNTW'(MAX_SHELVES));
    assign reach2  = {reach_reg, 1'b0};
    assign side2   = {side_reg, 1'b0};

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        count_next     = count_reg;
        acount_next    = acount_reg;
        scan_next      = scan_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        init_next      = init_reg;
        maxs_next      = maxs_reg;
        reach_next     = reach_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        fresh_next     = fresh_reg;
        resized_next   = resized_reg;
        big_next       = big_reg;
        out_valid_next = out_valid_reg & out_stall;
        out_load       = 1'b0;
        launch         = 1'b0;
        kill           = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = '0;
        wr_x           = '0;
        wr_y           = '0;
        wr_ext         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    w_next       = glyph_width;
                    h_next       = glyph_height;
                    init_next    = init_clamp;
                    maxs_next    = max_clamp;
                    reach_next   = init_clamp;
                    px_next      = '0;
                    py_next      = '0;
                    fresh_next   = 1'b0;
                    resized_next = 1'b0;
                    big_next     = 1'b0;
                    // first glyph ever: open the first atlas
                    if (acount_reg == '0)
                    begin
                        side_next   = init_clamp;
                        count_next  = CNTW'(1);
                        acount_next = ACOUNT_W'(1);
                        fresh_next  = 1'b1;
                        wr_en       = 1'b1;
                    end
                    state_next = ST_REACH;
                end
            end

            ST_REACH:
            begin
                // largest side reachable from a fresh atlas
                if (reach2 <= {1'b0, maxs_reg})
                begin
                    reach_next = reach2[SW-1:0];
                end
                else if ((SW'(w_reg) >= reach_reg) || (SW'(h_reg) >= reach_reg))
                begin
                    big_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LAUNCH;
                end
            end

            ST_LAUNCH:
            begin
                launch     = 1'b1;
                scan_next  = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (fits && (is_last || (ye < {1'b0, rd_ext})))
                begin
                    // place on this shelf; last shelf may grow
                    kill       = 1'b1;
                    wr_en      = 1'b1;
                    wr_idx     = scan_reg;
                    wr_x       = nx[SW-1:0];
                    wr_y       = rd_y;
                    wr_ext     = (is_last && (ye > {1'b0, rd_ext})) ? ye[SW-1:0] : rd_ext;
                    px_next    = rd_x;
                    py_next    = rd_y;
                    state_next = ST_FINISH;
                end
                else if (is_last)
                begin
                    kill = 1'b1;
                    if (room)
                    begin
                        // open a new shelf below the last one
                        wr_en      = 1'b1;
                        wr_idx     = count_reg[IW-1:0];
                        wr_x       = SW'((SW+1)'(w_reg) + (SW+1)'(1));
                        wr_y       = ny[SW-1:0];
                        wr_ext     = ne[SW-1:0];
                        count_next = count_reg + CNTW'(1);
                        px_next    = '0;
                        py_next    = ny[SW-1:0];
                        state_next = ST_FINISH;
                    end
                    else if (side2 > {1'b0, maxs_reg})
                    begin
                        // cannot double: fresh atlas with one empty shelf
                        side_next    = init_reg;
                        count_next   = CNTW'(1);
                        acount_next  = (acount_reg < COUNT_CAP) ?
                                       acount_reg + ACOUNT_W'(1) : acount_reg;
                        fresh_next   = 1'b1;
                        resized_next = 1'b0;
                        wr_en        = 1'b1;
                        state_next   = ST_LAUNCH;
                    end
                    else
                    begin
                        side_next    = side2[SW-1:0];
                        resized_next = 1'b1;
                        state_next   = ST_LAUNCH;
                    end
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // -------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            side_reg      <= '0;
            count_reg     <= '0;
            acount_reg    <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            cfg_init_reg  <= INIT_SIZE_RESET;
            cfg_max_reg   <= MAX_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            count_reg     <= count_next;
            acount_reg    <= acount_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_INIT_SIZE))
            begin
                cfg_init_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_MAX_SIZE))
            begin
                cfg_max_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg       <= w_next;
        h_reg       <= h_next;
        init_reg    <= init_next;
        maxs_reg    <= maxs_next;
        reach_reg   <= reach_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        fresh_reg   <= fresh_next;
        resized_reg <= resized_next;
        big_reg     <= big_next;
        if (out_load)
        begin
            ox_reg    <= px_reg[GLYPH_W-1:0];
            oy_reg    <= py_reg[GLYPH_W-1:0];
            oidx_reg  <= AIDX_W'(acount_reg - ACOUNT_W'(1));
            oside_reg <= side_reg[CFG_W-1:0];
            ores_reg  <= resized_reg;
            onew_reg  <= fresh_reg;
            obig_reg  <= big_reg;
        end
    end

    // ---------------------------------------------------------------- outputs
    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign place_x       = ox_reg;
    assign place_y       = oy_reg;
    assign atlas_index   = oidx_reg;
    assign atlas_side    = oside_reg;
    assign was_resized   = ores_reg;
    assign was_new_atlas = onew_reg;
    assign too_large     = obig_reg;

endmodule

// ----- src/sap_checker.sv -----
// ----------------------------------------------------------------------------
// sap_checker
// port-level checks of the shelf atlas packer
// ----------------------------------------------------------------------------
`include "shelf_atlas_packer_macros.svh"

module sap_checker
    import sap_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [GLYPH_W-1:0] place_x,
    input logic [GLYPH_W-1:0] place_y,
    input logic               was_resized,
    input logic               too_large
);

    // a stalled result stays offered
    `SAP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // one glyph at a time: busy right after an input transfer
    `SAP_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)

    // an oversized glyph places nothing and never grows the atlas
    `SAP_ASSERT_IMP(a_big_empty, clk, rst_n, out_valid && too_large,
                    (place_x == '0) && (place_y == '0) && !was_resized)

    // results only appear out of a busy cycle
    `SAP_ASSERT_IMP(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind shelf_atlas_packer sap_checker u_sap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .place_x     (place_x),
    .place_y     (place_y),
    .was_resized (was_resized),
    .too_large   (too_large)
);
